>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the encoder RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PSE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSE_ASSERT(lbl, clk, rstn, prop, msg)
`define PSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, codes and inter-module types of the PNG stream encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int W_DIM  = 14;
    localparam int W_ROWB = 16;
    localparam int W_FILT = 29;
    localparam int W_IDAT = 32;
    localparam int W_CFGI = 2;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [W_DIM-1:0]  MaxDim    = 14'd8192;
    localparam logic [15:0]       BlockMax  = 16'hffff;
    localparam logic [16:0]       AdlerMod  = 17'd65521;
    localparam logic [31:0]       CrcPoly   = 32'hedb88320;

    localparam logic [W_CFGI-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [W_CFGI-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [W_CFGI-1:0] CFG_ALPHA  = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } head_t;

    typedef struct packed {
        logic              pop;
        logic              header_sent;
    } back_ctl_t;

    typedef struct packed {
        logic [W_DIM-1:0]  width;
        logic [W_DIM-1:0]  height;
        logic              alpha;
        logic [W_ROWB-1:0] row_len;
        logic [W_FILT-1:0] filt;
        logic [W_IDAT-1:0] idat;
    } geom_t;

endpackage

>>> design/pse_stream_if.sv
// ----------------------------------------------------------------------------
// pse_stream_if
// Valid/ready channels for pixel bytes in and PNG bytes out.
// ----------------------------------------------------------------------------
interface pse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface pse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_last;
    modport source (output valid, output out_byte, output run_last, output file_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input file_last,
                    output ready);
endinterface

>>> design/png_uncompressed_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// png_uncompressed_stream_encoder_unit
// Streaming PNG writer with stored deflate blocks, CRC-32 and Adler-32.
// ----------------------------------------------------------------------------
// Feed raw channel bytes, row-major with channels interleaved; out comes a
// complete PNG file, one byte per clock on the output channel while the sink
// is ready and an item is queued. An ordinary pixel item yields one byte, so
// pixels then stream at one item per cycle. The byte sequencer emits one
// output byte a cycle unless stalled, so an item that also opens a row adds
// one byte (filter byte), one that crosses a stored block boundary five more,
// the first item of a file 43 more (signature, IHDR, IDAT head, zlib header)
// and the final item 20 more (Adler-32, IDAT CRC, IEND). A four-deep input
// queue lets the source keep pushing while these runs go out. Write the
// geometry registers only between files; writes during a file are dropped.

module png_uncompressed_stream_encoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    pse_in_if.sink                      pix,
    pse_out_if.source                   png,
    input  logic                        cfg_we,
    input  logic [pse_pkg::W_CFGI-1:0]  cfg_index,
    input  logic [pse_pkg::W_DIM-1:0]   cfg_data
);

    logic [pse_pkg::W_DIM-1:0]  width_reg, height_reg;
    logic                       alpha_reg;
    logic [pse_pkg::W_DIM-1:0]  dim_clamped;
    logic [pse_pkg::W_ROWB-1:0] row_len;
    logic [pse_pkg::W_FILT-1:0] filt_reg;
    logic [13:0]                blocks_reg;
    logic [pse_pkg::W_IDAT-1:0] idat_reg;
    logic [pse_pkg::W_FILT-1:0] prod;
    logic [12:0]                q0;
    logic [16:0]                r0, r1;
    logic                       r_ge;
    logic [13:0]                q1;
    pse_pkg::head_t             head;
    pse_pkg::back_ctl_t         ctl;
    pse_pkg::geom_t             geom;

    // Clamp a dimension into 1..MaxDim
    always_comb
    begin
        if (cfg_data == '0)
        begin
            dim_clamped = pse_pkg::W_DIM'(1);
        end
        else if (cfg_data > pse_pkg::MaxDim)
        begin
            dim_clamped = pse_pkg::MaxDim;
        end
        else
        begin
            dim_clamped = cfg_data;
        end
    end

    // Hold geometry while a file is open
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pse_pkg::W_DIM'(1);
            height_reg <= pse_pkg::W_DIM'(1);
            alpha_reg  <= 1'b1;
        end
        else if (cfg_we && !ctl.header_sent)
        begin
            case (cfg_index)
                pse_pkg::CFG_WIDTH:  width_reg  <= dim_clamped;
                pse_pkg::CFG_HEIGHT: height_reg <= dim_clamped;
                pse_pkg::CFG_ALPHA:  alpha_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Bytes per row: width * 3 or width * 4
    assign row_len = alpha_reg ? {width_reg, 2'b00}
                               : ({2'b00, width_reg} + {1'b0, width_reg, 1'b0});

    // Size pipeline: filtered bytes, stored block count, then IDAT length.
    // Division by 65535: quotient guess from the top bits, one correction.
    assign prod = pse_pkg::W_FILT'(({1'b0, row_len} + 17'd1) * height_reg);
    assign q0   = filt_reg[28:16];
    assign r0   = {1'b0, filt_reg[15:0]} + {4'd0, q0};
    assign r_ge = (r0 >= 17'd65535);
    assign r1   = r_ge ? (r0 - 17'd65535) : r0;
    assign q1   = {1'b0, q0} + {13'd0, r_ge};

    always_ff @(posedge clk)
    begin
        filt_reg   <= prod;
        blocks_reg <= q1 + {13'd0, (r1 != '0)};
        idat_reg   <= 32'd6 + {3'd0, filt_reg} + {16'd0, blocks_reg, 2'b00}
                      + {18'd0, blocks_reg};
    end

    assign geom.width   = width_reg;
    assign geom.height  = height_reg;
    assign geom.alpha   = alpha_reg;
    assign geom.row_len = row_len;
    assign geom.filt    = filt_reg;
    assign geom.idat    = idat_reg;

    pse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_data  (pix.pixel_byte),
        .in_ready (pix.ready),
        .pop      (ctl.pop),
        .head     (head)
    );

    pse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .geom          (geom),
        .ctl           (ctl),
        .out_valid     (png.valid),
        .out_ready     (png.ready),
        .out_byte      (png.out_byte),
        .out_run_last  (png.run_last),
        .out_file_last (png.file_last)
    );

endmodule

>>> design/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front
// Input queue: accept pixel items and present the oldest one to the emitter.
// ----------------------------------------------------------------------------
module pse_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [7:0]      in_data,
    output logic            in_ready,
    input  logic            pop,
    output pse_pkg::head_t  head
);

    logic [7:0]             q_mem [pse_pkg::QDEPTH];
    logic [pse_pkg::QAW-1:0] wr_ptr_reg;
    logic [pse_pkg::QAW-1:0] rd_ptr_reg;
    logic [pse_pkg::QAW:0]   cnt_reg;
    logic [pse_pkg::QAW:0]   cnt_next;
    logic                    push;

    assign in_ready = (cnt_reg != pse_pkg::QAW'(0) + (pse_pkg::QAW+1)'(pse_pkg::QDEPTH));
    assign push     = in_valid && in_ready;
    assign head.valid = (cnt_reg != '0);
    assign head.data  = q_mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back
// Byte sequencer: emit header, block headers, filter bytes, pixels, trailer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pse_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pse_pkg::head_t       head,
    input  pse_pkg::geom_t       geom,
    output pse_pkg::back_ctl_t   ctl,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_run_last,
    output logic                 out_file_last
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR, PH_BLK, PH_FILT, PH_PIX, PH_TRL
    } phase_t;

    localparam logic [5:0] HdrLast = 6'd42;
    localparam logic [5:0] BlkLast = 6'd4;
    localparam logic [5:0] TrlLast = 6'd19;

    phase_t                     ph_reg, ph_next, cur_ph, pick_ph;
    logic [5:0]                 idx_reg, idx_next, cur_idx;
    logic                       sent_reg;
    logic [31:0]                crc_reg, crc_base, crc_next;
    logic [15:0]                adl_lo_reg, adl_hi_reg;
    logic [pse_pkg::W_ROWB-1:0] rbc_reg;
    logic [15:0]                blk_reg;
    logic [pse_pkg::W_FILT-1:0] filt_reg;
    logic                       adv;
    logic [7:0]                 byte_val;
    logic                       crc_use, crc_rst, last, flast;
    logic                       do_data, do_pix, do_blk, do_load, do_end;
    logic [15:0]                blk_len;
    logic                       blk_final;
    logic [31:0]                ncrc;
    logic [16:0]                lo_s, lo_n, hi_s, hi_n;

    function automatic logic [31:0] crc8(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ pse_pkg::CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

    assign adv  = head.valid && (!out_valid || out_ready);
    assign ncrc = ~crc_reg;
    assign blk_final = (filt_reg <= pse_pkg::W_FILT'(pse_pkg::BlockMax));
    assign blk_len   = blk_final ? filt_reg[15:0] : pse_pkg::BlockMax;

    always_comb
    begin
        if (blk_reg == '0)
        begin
            pick_ph = PH_BLK;
        end
        else if (rbc_reg == '0)
        begin
            pick_ph = PH_FILT;
        end
        else
        begin
            pick_ph = PH_PIX;
        end
        if (ph_reg == PH_IDLE)
        begin
            cur_ph  = sent_reg ? pick_ph : PH_HDR;
            cur_idx = '0;
        end
        else
        begin
            cur_ph  = ph_reg;
            cur_idx = idx_reg;
        end
    end

    always_comb
    begin
        byte_val = '0;
        crc_use  = 1'b0;
        crc_rst  = 1'b0;
        last     = 1'b0;
        flast    = 1'b0;
        do_data  = 1'b0;
        do_pix   = 1'b0;
        do_blk   = 1'b0;
        do_load  = 1'b0;
        do_end   = 1'b0;
        ph_next  = cur_ph;
        idx_next = cur_idx + 1'b1;
        case (cur_ph)
            PH_HDR:
            begin
                case (cur_idx)
                    6'd0:  byte_val = 8'h89;
                    6'd1:  byte_val = 8'h50;
                    6'd2:  byte_val = 8'h4e;
                    6'd3:  byte_val = 8'h47;
                    6'd4:  byte_val = 8'h0d;
                    6'd5:  byte_val = 8'h0a;
                    6'd6:  byte_val = 8'h1a;
                    6'd7:  byte_val = 8'h0a;
                    6'd11: byte_val = 8'h0d;
                    6'd12: byte_val = 8'h49;
                    6'd13: byte_val = 8'h48;
                    6'd14: byte_val = 8'h44;
                    6'd15: byte_val = 8'h52;
                    6'd18: byte_val = {2'b00, geom.width[13:8]};
                    6'd19: byte_val = geom.width[7:0];
                    6'd22: byte_val = {2'b00, geom.height[13:8]};
                    6'd23: byte_val = geom.height[7:0];
                    6'd24: byte_val = 8'h08;
                    6'd25: byte_val = geom.alpha ? 8'h06 : 8'h02;
                    6'd29: byte_val = ncrc[31:24];
                    6'd30: byte_val = ncrc[23:16];
                    6'd31: byte_val = ncrc[15:8];
                    6'd32: byte_val = ncrc[7:0];
                    6'd33: byte_val = geom.idat[31:24];
                    6'd34: byte_val = geom.idat[23:16];
                    6'd35: byte_val = geom.idat[15:8];
                    6'd36: byte_val = geom.idat[7:0];
                    6'd37: byte_val = 8'h49;
                    6'd38: byte_val = 8'h44;
                    6'd39: byte_val = 8'h41;
                    6'd40: byte_val = 8'h54;
                    6'd41: byte_val = 8'h78;
                    6'd42: byte_val = 8'h01;
                    default: byte_val = 8'h00;
                endcase
                crc_use = (cur_idx >= 6'd12 && cur_idx <= 6'd28) || (cur_idx >= 6'd37);
                crc_rst = (cur_idx == 6'd12) || (cur_idx == 6'd37);
                if (cur_idx == HdrLast)
                begin
                    do_load  = 1'b1;
                    ph_next  = PH_BLK;
                    idx_next = '0;
                end
            end
            PH_BLK:
            begin
                case (cur_idx)
                    6'd0:    byte_val = {7'd0, blk_final};
                    6'd1:    byte_val = blk_len[7:0];
                    6'd2:    byte_val = blk_len[15:8];
                    6'd3:    byte_val = ~blk_len[7:0];
                    default: byte_val = ~blk_len[15:8];
                endcase
                crc_use = 1'b1;
                if (cur_idx == BlkLast)
                begin
                    do_blk   = 1'b1;
                    ph_next  = (rbc_reg == '0) ? PH_FILT : PH_PIX;
                    idx_next = '0;
                end
            end
            PH_FILT:
            begin
                byte_val = 8'h00;
                crc_use  = 1'b1;
                do_data  = 1'b1;
                ph_next  = (blk_reg == 16'd1) ? PH_BLK : PH_PIX;
                idx_next = '0;
            end
            PH_PIX:
            begin
                byte_val = head.data;
                crc_use  = 1'b1;
                do_data  = 1'b1;
                do_pix   = 1'b1;
                idx_next = '0;
                if (filt_reg == pse_pkg::W_FILT'(1))
                begin
                    ph_next = PH_TRL;
                end
                else
                begin
                    ph_next = PH_IDLE;
                    last    = 1'b1;
                end
            end
            PH_TRL:
            begin
                case (cur_idx)
                    6'd0:  byte_val = adl_hi_reg[15:8];
                    6'd1:  byte_val = adl_hi_reg[7:0];
                    6'd2:  byte_val = adl_lo_reg[15:8];
                    6'd3:  byte_val = adl_lo_reg[7:0];
                    6'd4:  byte_val = ncrc[31:24];
                    6'd5:  byte_val = ncrc[23:16];
                    6'd6:  byte_val = ncrc[15:8];
                    6'd7:  byte_val = ncrc[7:0];
                    6'd12: byte_val = 8'h49;
                    6'd13: byte_val = 8'h45;
                    6'd14: byte_val = 8'h4e;
                    6'd15: byte_val = 8'h44;
                    6'd16: byte_val = ncrc[31:24];
                    6'd17: byte_val = ncrc[23:16];
                    6'd18: byte_val = ncrc[15:8];
                    6'd19: byte_val = ncrc[7:0];
                    default: byte_val = 8'h00;
                endcase
                crc_use = (cur_idx <= 6'd3) || (cur_idx >= 6'd12 && cur_idx <= 6'd15);
                crc_rst = (cur_idx == 6'd12);
                if (cur_idx == TrlLast)
                begin
                    last     = 1'b1;
                    flast    = 1'b1;
                    do_end   = 1'b1;
                    ph_next  = PH_IDLE;
                    idx_next = '0;
                end
            end
            default:
            begin
                ph_next  = PH_IDLE;
                idx_next = '0;
            end
        endcase
    end

    // Adler-32 running sums and CRC-32 step, one byte per cycle while the sequencer advances
    always_comb
    begin
        lo_s = {1'b0, adl_lo_reg} + {9'd0, byte_val};
        lo_n = (lo_s >= pse_pkg::AdlerMod) ? (lo_s - pse_pkg::AdlerMod) : lo_s;
        hi_s = {1'b0, adl_hi_reg} + lo_n;
        hi_n = (hi_s >= pse_pkg::AdlerMod) ? (hi_s - pse_pkg::AdlerMod) : hi_s;
        crc_base = crc_rst ? 32'hffffffff : crc_reg;
        crc_next = crc_use ? crc8(crc_base, byte_val) : crc_reg;
    end

    assign ctl.pop         = adv && last;
    assign ctl.header_sent = sent_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte      <= byte_val;
            out_run_last  <= last;
            out_file_last <= flast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= PH_IDLE;
            idx_reg    <= '0;
            sent_reg   <= 1'b0;
            crc_reg    <= 32'hffffffff;
            adl_lo_reg <= 16'd1;
            adl_hi_reg <= '0;
            rbc_reg    <= '0;
            blk_reg    <= '0;
            filt_reg   <= '0;
            out_valid  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready && !adv)
            begin
                out_valid <= 1'b0;
            end
            if (adv)
            begin
                out_valid <= 1'b1;
                ph_reg    <= ph_next;
                idx_reg   <= idx_next;
                sent_reg  <= 1'b1;
                crc_reg   <= crc_next;
                if (do_load)
                begin
                    filt_reg <= geom.filt;
                end
                if (do_blk)
                begin
                    blk_reg <= blk_len;
                end
                if (do_data)
                begin
                    adl_lo_reg <= lo_n[15:0];
                    adl_hi_reg <= hi_n[15:0];
                    blk_reg    <= blk_reg - 1'b1;
                    filt_reg   <= filt_reg - 1'b1;
                    rbc_reg    <= rbc_reg + 1'b1;
                end
                if (do_pix && (rbc_reg == geom.row_len))
                begin
                    rbc_reg <= '0;
                end
                if (do_end)
                begin
                    sent_reg   <= 1'b0;
                    crc_reg    <= 32'hffffffff;
                    adl_lo_reg <= 16'd1;
                    adl_hi_reg <= '0;
                    rbc_reg    <= '0;
                    blk_reg    <= '0;
                    filt_reg   <= '0;
                end
            end
        end
    end

    `PSE_ASSERT(a_flast_ends_run, clk, rst_n, out_valid && out_file_last |-> out_run_last, "file end off run")
    `PSE_ASSERT(a_busy_sent, clk, rst_n, (ph_reg != PH_IDLE) |-> sent_reg, "phase without file")
    `PSE_ASSERT_ALWAYS(a_pop_head, clk, ctl.pop |-> head.valid, "pop with empty queue")

endmodule
